// ===== design/mlfd_pkg.sv =====
// Shared constants for the magic/length frame deframer.
// Result kind codes, input operation codes and header constants.
// No dependencies.
package mlfd_pkg;

  // Input operation codes (in_tuser)
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_RESET = 1'b1;

  // Result kind codes (out_tuser)
  localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [2:0] KIND_EMPTY    = 3'd1;
  localparam logic [2:0] KIND_BAD_MAG  = 3'd2;
  localparam logic [2:0] KIND_BAD_LEN  = 3'd3;
  localparam logic [2:0] KIND_OFS_REF  = 3'd4;
  localparam logic [2:0] KIND_OVF_REF  = 3'd5;
  localparam logic [2:0] KIND_RESET    = 3'd6;

  // Frame header: 'E', 'Z', then a little-endian payload length
  localparam logic [7:0] MAGIC_B0 = 8'h45;
  localparam logic [7:0] MAGIC_B1 = 8'h5A;
  localparam int         HDR_LEN  = 4;

endpackage

// ===== design/mlfd_front.sv =====
// Front end of the deframer: write tracking, header parsing and classification.
// Produces at most one result per accepted byte. Depends on mlfd_pkg.
module mlfd_front
  import mlfd_pkg::*;
#(
  parameter int PAYLOAD_LIMIT = 512
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_fire,
  input  logic                                  in_op,
  input  logic [7:0]                            in_byte,
  input  logic                                  in_start,
  input  logic [15:0]                           in_wlen,
  input  logic                                  in_ofs,
  output logic                                  res_valid,
  output logic [2:0]                            res_kind,
  output logic                                  res_last,
  output logic [7:0]                            res_byte,
  output logic [$clog2(PAYLOAD_LIMIT+1)-1:0]    res_flen,
  output logic                                  res_aborted
);

  localparam int LEN_W  = $clog2(PAYLOAD_LIMIT + 1);
  localparam int CAP    = 2 * (HDR_LEN + PAYLOAD_LIMIT);
  localparam int PEND_W = $clog2(CAP + 1);

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_HDR2 = 3'd2;
  localparam logic [2:0] PH_HDR3 = 3'd3;
  localparam logic [2:0] PH_PAY  = 3'd4;

  logic [2:0]        phase_r, phase_nxt;
  logic [7:0]        hb0_r, hb0_nxt, hb1_r, hb1_nxt, hb2_r, hb2_nxt;
  logic [LEN_W-1:0]  total_r, total_nxt, seen_r, seen_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic              disc_r, disc_nxt;

  logic [15:0]       wlen;
  logic [16:0]       room;
  logic [15:0]       plen;
  logic [LEN_W-1:0]  seen_inc;
  logic              go;
  logic              disc_v;

  assign wlen     = (in_wlen == 16'd0) ? 16'd1 : in_wlen;
  assign room     = 17'(CAP) - 17'(pend_r);
  assign plen     = {in_byte, hb2_r};
  assign seen_inc = seen_r + 1'b1;

  // Classify the byte and compute the next write and frame state
  always_comb begin
    phase_nxt   = phase_r;
    hb0_nxt     = hb0_r;
    hb1_nxt     = hb1_r;
    hb2_nxt     = hb2_r;
    total_nxt   = total_r;
    seen_nxt    = seen_r;
    pend_nxt    = pend_r;
    rem_nxt     = rem_r;
    disc_nxt    = disc_r;
    go          = 1'b0;
    disc_v      = disc_r;
    res_valid   = 1'b0;
    res_kind    = KIND_PAYLOAD;
    res_last    = 1'b0;
    res_byte    = 8'd0;
    res_flen    = '0;
    res_aborted = 1'b0;

    if (in_fire) begin
      if (in_op == OP_RESET) begin
        // Drop the whole session
        res_valid   = 1'b1;
        res_kind    = KIND_RESET;
        res_aborted = (pend_r != '0);
        phase_nxt   = PH_HDR0;
        hb0_nxt     = 8'd0;
        hb1_nxt     = 8'd0;
        hb2_nxt     = 8'd0;
        total_nxt   = '0;
        seen_nxt    = '0;
        pend_nxt    = '0;
        rem_nxt     = 16'd0;
        disc_nxt    = 1'b0;
      end else begin
        go = 1'b1;
        if (in_start) begin
          disc_v   = 1'b0;
          disc_nxt = 1'b0;
          rem_nxt  = wlen - 16'd1;
          if (in_ofs) begin
            // Refuse the write, keep the frame
            disc_nxt  = 1'b1;
            res_valid = 1'b1;
            res_kind  = KIND_OFS_REF;
            go        = 1'b0;
          end else if ({1'b0, wlen} > room) begin
            // Refuse the write and abort any partial frame
            disc_nxt    = 1'b1;
            res_valid   = 1'b1;
            res_kind    = KIND_OVF_REF;
            res_aborted = (pend_r != '0);
            phase_nxt   = PH_HDR0;
            hb0_nxt     = 8'd0;
            hb1_nxt     = 8'd0;
            hb2_nxt     = 8'd0;
            total_nxt   = '0;
            seen_nxt    = '0;
            pend_nxt    = '0;
            go          = 1'b0;
          end
        end else if (rem_r == 16'd0) begin
          // Stray byte outside any write
          go = 1'b0;
        end else begin
          rem_nxt = rem_r - 16'd1;
        end

        if (go && !disc_v) begin
          pend_nxt = pend_r + 1'b1;
          unique case (phase_r)
            PH_HDR0: begin
              hb0_nxt   = in_byte;
              phase_nxt = PH_HDR1;
            end
            PH_HDR1: begin
              hb1_nxt   = in_byte;
              phase_nxt = PH_HDR2;
            end
            PH_HDR2: begin
              hb2_nxt   = in_byte;
              phase_nxt = PH_HDR3;
            end
            PH_HDR3: begin
              if (hb0_r != MAGIC_B0 || hb1_r != MAGIC_B1 ||
                  plen > 16'(PAYLOAD_LIMIT) || plen == 16'd0) begin
                // Header rejected or empty frame: start over
                res_valid = 1'b1;
                phase_nxt = PH_HDR0;
                hb0_nxt   = 8'd0;
                hb1_nxt   = 8'd0;
                hb2_nxt   = 8'd0;
                total_nxt = '0;
                seen_nxt  = '0;
                pend_nxt  = '0;
                if (hb0_r != MAGIC_B0 || hb1_r != MAGIC_B1) begin
                  res_kind = KIND_BAD_MAG;
                  disc_nxt = 1'b1;
                end else if (plen > 16'(PAYLOAD_LIMIT)) begin
                  res_kind = KIND_BAD_LEN;
                  disc_nxt = 1'b1;
                end else begin
                  res_kind = KIND_EMPTY;
                end
              end else begin
                total_nxt = plen[LEN_W-1:0];
                seen_nxt  = '0;
                phase_nxt = PH_PAY;
              end
            end
            PH_PAY: begin
              res_valid = 1'b1;
              res_kind  = KIND_PAYLOAD;
              res_byte  = in_byte;
              res_flen  = total_r;
              seen_nxt  = seen_inc;
              if (seen_inc >= total_r) begin
                // Final payload byte closes the frame
                res_last  = 1'b1;
                phase_nxt = PH_HDR0;
                hb0_nxt   = 8'd0;
                hb1_nxt   = 8'd0;
                hb2_nxt   = 8'd0;
                total_nxt = '0;
                seen_nxt  = '0;
                pend_nxt  = '0;
              end
            end
            default: begin
              phase_nxt = PH_HDR0;
            end
          endcase
        end
      end
    end
  end

  // Hold the parser and write state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      hb0_r   <= 8'd0;
      hb1_r   <= 8'd0;
      hb2_r   <= 8'd0;
      total_r <= '0;
      seen_r  <= '0;
      pend_r  <= '0;
      rem_r   <= 16'd0;
      disc_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hb0_r   <= hb0_nxt;
      hb1_r   <= hb1_nxt;
      hb2_r   <= hb2_nxt;
      total_r <= total_nxt;
      seen_r  <= seen_nxt;
      pend_r  <= pend_nxt;
      rem_r   <= rem_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule

// ===== design/mlfd_fifo.sv =====
// Small result queue between the front end and the output port.
// Register-based, one push and one pop per cycle. No package dependency.
module mlfd_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             not_empty,
  input  logic             pop,
  output logic [WIDTH-1:0] head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/magic_length_frame_deframer_top.sv =====
// Frame deframer for 'E','Z' + 16-bit length headers carried in host write bytes.
// One byte is taken per clock; its result, if any, enters the result queue and shows
// on the out_ side in the cycle after the transfer at the earliest. Results sit in a
// four-entry queue, so the input side keeps taking bytes while the output side stalls
// and only backs off (in_tready low) once four results are waiting. Payload bytes leave
// cut-through; bytes of an incomplete frame are only counted, against a budget of
// 2*(4+PAYLOAD_LIMIT) bytes that decides whether a new write fits.
// Top level: instantiates mlfd_front and mlfd_fifo; depends on mlfd_pkg.
module magic_length_frame_deframer_top #(
  parameter int PAYLOAD_LIMIT = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // data_byte[7:0], write_start[8], write_length[24:9], offset_nonzero[25], zero[31:26]
  input  logic [31:0]                 in_tdata,
  // operation[0]
  input  logic                        in_tuser,
  // Result channel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // payload_byte[7:0], frame_length[LEN_W+7:8], partial_aborted[LEN_W+8], zero above
  output logic [((8 + $clog2(PAYLOAD_LIMIT + 1) + 1 + 7) / 8) * 8 - 1:0] out_tdata,
  // kind[2:0]
  output logic [2:0]                  out_tuser,
  output logic                        out_tlast
);

  localparam int LEN_W      = $clog2(PAYLOAD_LIMIT + 1);
  localparam int OUT_RAW    = 8 + LEN_W + 1;
  localparam int OUT_DATA_W = ((OUT_RAW + 7) / 8) * 8;
  localparam int Q_W        = 3 + 1 + OUT_RAW;
  localparam int Q_DEPTH    = 4;

  logic             in_fire;
  logic             res_valid;
  logic [2:0]       res_kind;
  logic             res_last;
  logic [7:0]       res_byte;
  logic [LEN_W-1:0] res_flen;
  logic             res_aborted;
  logic             q_full;
  logic [Q_W-1:0]   q_head;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  // Parse and classify each accepted byte
  mlfd_front #(
    .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_op       (in_tuser),
    .in_byte     (in_tdata[7:0]),
    .in_start    (in_tdata[8]),
    .in_wlen     (in_tdata[24:9]),
    .in_ofs      (in_tdata[25]),
    .res_valid   (res_valid),
    .res_kind    (res_kind),
    .res_last    (res_last),
    .res_byte    (res_byte),
    .res_flen    (res_flen),
    .res_aborted (res_aborted)
  );

  // Queue results toward the output port
  mlfd_fifo #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data ({res_kind, res_last, res_aborted, res_flen, res_byte}),
    .full      (q_full),
    .not_empty (out_tvalid),
    .pop       (out_tready),
    .head      (q_head)
  );

  // Unpack the queue head onto the output channel
  assign out_tuser = q_head[Q_W-1 -: 3];
  assign out_tlast = q_head[OUT_RAW];
  assign out_tdata = OUT_DATA_W'(q_head[OUT_RAW-1:0]);

endmodule

// ===== design/mlfd_checker.sv =====
// Port-level checker for the deframer, bound to the top level.
// Depends on mlfd_pkg and magic_length_frame_deframer_top.
module mlfd_checker
  import mlfd_pkg::*;
#(
  parameter int PAYLOAD_LIMIT = 512
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [((8 + $clog2(PAYLOAD_LIMIT + 1) + 1 + 7) / 8) * 8 - 1:0] out_tdata,
  input logic [2:0]                  out_tuser,
  input logic                        out_tlast
);

  localparam int LEN_W = $clog2(PAYLOAD_LIMIT + 1);

  // A frame end mark belongs only to a payload byte
  a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_PAYLOAD)
    else $error("frame end marked on a non-payload result");

  // Frame length is reported only for payload bytes
  a_flen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_PAYLOAD |-> out_tdata[LEN_W+7:8] == '0)
    else $error("frame length on a non-payload result");

  // Payload length never exceeds the configured maximum
  a_flen_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_PAYLOAD |->
      out_tdata[LEN_W+7:8] <= LEN_W'(PAYLOAD_LIMIT) && out_tdata[LEN_W+7:8] != '0)
    else $error("payload frame length out of range");

  // Abort flag only with overflow refusal or session reset
  a_abort_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[LEN_W+8] |->
      out_tuser == KIND_OVF_REF || out_tuser == KIND_RESET)
    else $error("abort flag on an unexpected kind");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind magic_length_frame_deframer_top mlfd_checker #(
  .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
) u_mlfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
